// ===== hdl/midi_track_event_serializer_core_assert.svh =====
// ----------------------------------------------------------------------------
// midi track event serializer assertion macros
// concurrent checks on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef MIDI_TRACK_EVENT_SERIALIZER_CORE_ASSERT_SVH
`define MIDI_TRACK_EVENT_SERIALIZER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define MTES_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mtes same-cycle check failed");
`define MTES_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mtes next-cycle check failed");
`else
`define MTES_ASSERT_NOW(lbl, ante, cons)
`define MTES_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hdl/mtes_pkg.sv =====
// ----------------------------------------------------------------------------
// mtes_pkg
// shared types and constants of the midi track event serializer
// ----------------------------------------------------------------------------
`default_nettype none

package mtes_pkg;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_EVENT = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  localparam int unsigned TICK_W = 30;

  // reciprocals for division by 125
  localparam logic [16:0] DIV_M16 = 17'd67109;
  localparam logic [23:0] DIV_M23 = 24'd8589935;
  localparam logic [12:0] DIV_M12 = 13'd4195;

  localparam logic [27:0] DELTA_MAX = 28'hFFFFFFF;

  localparam logic [7:0] META_PREFIX = 8'hFF;
  localparam logic [7:0] META_TEMPO  = 8'h51;
  localparam logic [7:0] META_EOT    = 8'h2F;
  localparam logic [7:0] TEMPO_LEN   = 8'h03;
  localparam logic [7:0] TEMPO_B2    = 8'h07;
  localparam logic [7:0] TEMPO_B1    = 8'hA1;
  localparam logic [7:0] TEMPO_B0    = 8'h20;

  localparam logic [3:0] NIB_NOTE_OFF  = 4'h8;
  localparam logic [3:0] NIB_NOTE_ON   = 4'h9;
  localparam logic [3:0] NIB_POLY_AT   = 4'hA;
  localparam logic [3:0] NIB_CTRL      = 4'hB;
  localparam logic [3:0] NIB_PROGRAM   = 4'hC;
  localparam logic [3:0] NIB_CHAN_AT   = 4'hD;
  localparam logic [3:0] NIB_PITCH     = 4'hE;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] status;
    logic [7:0] data1;
    logic [7:0] data2;
  } mtes_msg_t;

  typedef struct packed {
    mtes_msg_t         msg;
    logic [TICK_W-1:0] tick;
  } mtes_tick_item_t;

endpackage

`default_nettype wire

// ===== hdl/midi_track_event_serializer_core.sv =====
// ----------------------------------------------------------------------------
// midi_track_event_serializer_core
// timed midi messages in, standard midi file track body bytes out
//
// input channel: one item per message (start track, channel event, end of
// track) on in_valid/in_ready. result channel: the bytes of each item on
// out_valid/out_ready with out_last on the final byte of an input item and
// the running track byte count in out_track_bytes.
// an accepted item passes the six-stage ms-to-tick pipeline, then the byte
// serializer, which puts each byte in its registered output.
// the serializer loads one item, then sends its bytes one per cycle while
// out_ready allows, and takes the next item only once its last byte is out
// (start track 7 bytes, end of track 4, events 1 to 7, kind 3 items none).
// up to six further items queue in the tick pipeline while bytes go out.
// reset: previous tick and byte count clear, no bytes pending.
// stall: a held out_ready freezes the output register and the serializer;
// the pipeline then fills and in_ready drops. kind 3 items produce no bytes.
// ----------------------------------------------------------------------------
`default_nettype none

`include "midi_track_event_serializer_core_assert.svh"

module midi_track_event_serializer_core
  import mtes_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_time_ms,
  input  logic [7:0]  in_status,
  input  logic [7:0]  in_data1,
  input  logic [7:0]  in_data2,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic [31:0] out_track_bytes
);

  mtes_msg_t       in_msg;
  logic            tick_valid;
  logic            tick_ready;
  mtes_tick_item_t tick_item;
  logic            ser_busy;

  assign in_msg.kind   = in_kind;
  assign in_msg.status = in_status;
  assign in_msg.data1  = in_data1;
  assign in_msg.data2  = in_data2;

  mtes_tick_pipe u_tick_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_msg    (in_msg),
    .in_ms     (in_time_ms),
    .out_valid (tick_valid),
    .out_ready (tick_ready),
    .out_item  (tick_item)
  );

  mtes_serializer u_serializer (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (tick_valid),
    .in_ready        (tick_ready),
    .in_item         (tick_item),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_last        (out_last),
    .out_track_bytes (out_track_bytes),
    .busy            (ser_busy)
  );

  // more bytes of the same item still buffered
  `MTES_ASSERT_NOW(a_mid_item_busy, out_valid && out_ready && !out_last, ser_busy)
  // bytes of one item go out without gaps
  `MTES_ASSERT_NEXT(a_mid_item_no_gap, out_valid && out_ready && !out_last, out_valid)
  // byte count steps by one inside an item
  `MTES_ASSERT_NEXT(a_count_step, out_valid && out_ready && !out_last,
                    out_track_bytes == $past(out_track_bytes) + 32'd1)

endmodule

`default_nettype wire

// ===== hdl/mtes_tick_pipe.sv =====
// ----------------------------------------------------------------------------
// mtes_tick_pipe
// milliseconds to ticks, tick = floor(ms * 24 / 125), six register stages
// ----------------------------------------------------------------------------
`default_nettype none

module mtes_tick_pipe
  import mtes_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  mtes_msg_t       in_msg,
  input  logic [31:0]     in_ms,
  output logic            out_valid,
  input  logic            out_ready,
  output mtes_tick_item_t out_item
);

  localparam int NSTG = 6;

  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] ce;
  mtes_msg_t       msg_r [NSTG];

  logic [31:0]       ms0_r;
  logic [9:0]        qh1_r;
  logic [15:0]       h1_r;
  logic [15:0]       l1_r;
  logic [22:0]       x2_r;
  logic [9:0]        qh2_r;
  logic [15:0]       q3_r;
  logic [22:0]       x3_r;
  logic [9:0]        qh3_r;
  logic [TICK_W-1:0] tb4_r;
  logic [11:0]       fr4_r;
  logic [TICK_W-1:0] tick5_r;

  logic [32:0]       prod1;
  logic [16:0]       qh125;
  logic [15:0]       rh16;
  logic [46:0]       prod3;
  logic [25:0]       q26;
  logic [22:0]       q125;
  logic [22:0]       r23;
  logic [6:0]        r7;
  logic [24:0]       prod5;
  logic [5:0]        frac;

  always_comb begin
    ce[NSTG-1] = !vld_r[NSTG-1] || out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      ce[k] = !vld_r[k] || ce[k+1];
    end
  end

  assign in_ready = ce[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (ce[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (ce[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // arithmetic per stage
  assign prod1 = {16'd0, ms0_r[31:16]} * {16'd0, DIV_M16};
  assign qh125 = {7'd0, qh1_r} * 17'd125;
  assign rh16  = h1_r - qh125[15:0];
  assign prod3 = {24'd0, x2_r} * {23'd0, DIV_M23};
  assign q26   = {qh3_r, q3_r};
  assign q125  = {7'd0, q3_r} * 23'd125;
  assign r23   = x3_r - q125;
  assign r7    = r23[6:0];
  assign prod5 = {13'd0, fr4_r} * {12'd0, DIV_M12};
  assign frac  = prod5[24:19];

  always_ff @(posedge clk) begin
    if (ce[0]) begin
      msg_r[0] <= in_msg;
      ms0_r    <= in_ms;
    end
    for (int k = 1; k < NSTG; k++) begin
      if (ce[k]) begin
        msg_r[k] <= msg_r[k-1];
      end
    end
    if (ce[1]) begin
      qh1_r <= prod1[32:23];
      h1_r  <= ms0_r[31:16];
      l1_r  <= ms0_r[15:0];
    end
    if (ce[2]) begin
      x2_r  <= {rh16[6:0], l1_r};
      qh2_r <= qh1_r;
    end
    if (ce[3]) begin
      q3_r  <= prod3[45:30];
      x3_r  <= x2_r;
      qh3_r <= qh2_r;
    end
    if (ce[4]) begin
      tb4_r <= {q26, 4'd0} + {1'b0, q26, 3'd0};
      fr4_r <= {1'b0, r7, 4'd0} + {2'b0, r7, 3'd0};
    end
    if (ce[5]) begin
      tick5_r <= tb4_r + {{(TICK_W-6){1'b0}}, frac};
    end
  end

  assign out_valid     = vld_r[NSTG-1];
  assign out_item.msg  = msg_r[NSTG-1];
  assign out_item.tick = tick5_r;

endmodule

`default_nettype wire

// ===== hdl/mtes_serializer.sv =====
// ----------------------------------------------------------------------------
// mtes_serializer
// builds the track bytes of one item, sends them one per cycle when out_ready allows
// ----------------------------------------------------------------------------
`default_nettype none

module mtes_serializer
  import mtes_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  mtes_tick_item_t in_item,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_byte,
  output logic            out_last,
  output logic [31:0]     out_track_bytes,
  output logic            busy
);

  logic [TICK_W-1:0] prev_r;
  logic [31:0]       total_r;
  logic [6:0][7:0]   buf_r;
  logic [2:0]        rem_r;
  logic              out_valid_r;
  logic [7:0]        out_byte_r;
  logic              out_last_r;
  logic [31:0]       out_track_r;

  logic              load;
  logic              mv;
  logic [31:0]       delta;
  logic [27:0]       v;
  logic [2:0]        grp;
  logic [3:0][7:0]   vlq;
  logic [2:0][7:0]   msg_b;
  logic [2:0]        mlen;
  logic [2:0]        j;
  logic [6:0][7:0]   ev_b;
  logic [6:0][7:0]   enc;
  logic [2:0]        enc_n;

  always_comb begin
    delta = {{(32-TICK_W){1'b0}}, in_item.tick} - {{(32-TICK_W){1'b0}}, prev_r};
    v     = (delta[31:28] != 4'd0) ? DELTA_MAX : delta[27:0];
    priority if (v[27:21] != 7'd0) begin
      grp = 3'd4;
    end else if (v[20:14] != 7'd0) begin
      grp = 3'd3;
    end else if (v[13:7] != 7'd0) begin
      grp = 3'd2;
    end else begin
      grp = 3'd1;
    end
    vlq = '0;
    unique case (grp)
      3'd4: begin
        vlq[0] = {1'b1, v[27:21]};
        vlq[1] = {1'b1, v[20:14]};
        vlq[2] = {1'b1, v[13:7]};
        vlq[3] = {1'b0, v[6:0]};
      end
      3'd3: begin
        vlq[0] = {1'b1, v[20:14]};
        vlq[1] = {1'b1, v[13:7]};
        vlq[2] = {1'b0, v[6:0]};
      end
      3'd2: begin
        vlq[0] = {1'b1, v[13:7]};
        vlq[1] = {1'b0, v[6:0]};
      end
      default: begin
        vlq[0] = {1'b0, v[6:0]};
      end
    endcase
    msg_b[0] = in_item.msg.status;
    msg_b[1] = in_item.msg.data1;
    msg_b[2] = in_item.msg.data2;
    unique case (in_item.msg.status[7:4])
      NIB_NOTE_OFF, NIB_NOTE_ON, NIB_POLY_AT, NIB_CTRL, NIB_PITCH: mlen = 3'd3;
      NIB_PROGRAM, NIB_CHAN_AT:                                    mlen = 3'd2;
      default:                                                     mlen = 3'd0;
    endcase
    for (int i = 0; i < 7; i++) begin
      j = 3'(i) - grp;
      if (3'(i) < grp) begin
        ev_b[i] = vlq[i[1:0]];
      end else if (j < mlen) begin
        ev_b[i] = msg_b[j[1:0]];
      end else begin
        ev_b[i] = 8'h00;
      end
    end
    enc = '0;
    unique case (in_item.msg.kind)
      KIND_START: begin
        enc[0] = 8'h00;
        enc[1] = META_PREFIX;
        enc[2] = META_TEMPO;
        enc[3] = TEMPO_LEN;
        enc[4] = TEMPO_B2;
        enc[5] = TEMPO_B1;
        enc[6] = TEMPO_B0;
        enc_n  = 3'd7;
      end
      KIND_EVENT: begin
        enc   = ev_b;
        enc_n = grp + mlen;
      end
      KIND_END: begin
        enc[0] = 8'h00;
        enc[1] = META_PREFIX;
        enc[2] = META_EOT;
        enc[3] = 8'h00;
        enc_n  = 3'd4;
      end
      default: begin
        enc_n = 3'd0;
      end
    endcase
  end

  assign in_ready = (rem_r == 3'd0);
  assign load     = in_valid && in_ready;
  assign mv       = (rem_r != 3'd0) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= '0;
      total_r     <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        rem_r <= enc_n;
        if (in_item.msg.kind == KIND_START) begin
          prev_r  <= '0;
          total_r <= '0;
        end else if (in_item.msg.kind == KIND_EVENT) begin
          prev_r <= in_item.tick;
        end
      end
      if (mv) begin
        rem_r       <= rem_r - 3'd1;
        total_r     <= total_r + 32'd1;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_r <= enc;
    end else if (mv) begin
      buf_r <= {8'h00, buf_r[6:1]};
    end
    if (mv) begin
      out_byte_r  <= buf_r[0];
      out_last_r  <= (rem_r == 3'd1);
      out_track_r <= total_r + 32'd1;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_last        = out_last_r;
  assign out_track_bytes = out_track_r;
  assign busy            = (rem_r != 3'd0);

endmodule

`default_nettype wire
